### rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// Scan pattern point generator package
// Shared widths, codes, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int IDX_W   = 10;
  localparam int COORD_W = 10;
  localparam int ANG_W   = 19;
  localparam int Z_W     = 21;
  localparam int XY_W    = 26;
  localparam int FRAC_W  = 16;
  localparam int ATAN_W  = 16;
  localparam int STEP_W  = 5;

  localparam int COORD_SPAN_DEF   = 700;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [IDX_W-1:0]   RES_RESET = IDX_W'(10);
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(1023);
  localparam logic [ANG_W-1:0]   ANG_TURN  = ANG_W'(411566);

  localparam logic signed [Z_W-1:0]  ANG_PI_S      = Z_W'(205887);
  localparam logic signed [Z_W-1:0]  ANG_HALF_PI_S = Z_W'(102944);
  localparam logic signed [Z_W-1:0]  ANG_TWO_PI_S  = Z_W'(411775);
  localparam logic signed [XY_W-1:0] RADIUS_GAIN_S = XY_W'(7959386);
  localparam logic signed [XY_W-1:0] CENTER_S      = XY_W'(350);
  localparam logic signed [XY_W-1:0] TRUNC_RND_S   = XY_W'((1 << FRAC_W) - 1);

  localparam logic CFG_PATTERN = 1'b0;
  localparam logic CFG_RES     = 1'b1;

  localparam logic PAT_RASTER = 1'b0;
  localparam logic PAT_CIRCLE = 1'b1;

  localparam logic MODE_START  = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30385;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/scp_in_if.sv
// ----------------------------------------------------------------------------
// Scan pattern input channel
// Valid/ready channel carrying one request beat: mode and target reached.
// ----------------------------------------------------------------------------
interface scp_in_if;
  import scp_pkg::*;

  logic valid;
  logic ready;
  logic mode;
  logic target_reached;

  modport source (output valid, output mode, output target_reached, input ready);
  modport sink   (input valid, input mode, input target_reached, output ready);
endinterface

### rtl/scp_out_if.sv
// ----------------------------------------------------------------------------
// Scan pattern output channel
// Valid/ready channel carrying one result beat: move command and targets.
// ----------------------------------------------------------------------------
interface scp_out_if;
  import scp_pkg::*;

  logic               valid;
  logic               ready;
  logic               move_valid;
  logic [COORD_W-1:0] target_x;
  logic [COORD_W-1:0] target_y;
  logic               scan_finished;

  modport source (output valid, output move_valid, output target_x, output target_y,
                  output scan_finished, input ready);
  modport sink   (input valid, input move_valid, input target_x, input target_y,
                  input scan_finished, output ready);
endinterface

### rtl/scan_pattern_point_generator.sv
// ----------------------------------------------------------------------------
// Scan pattern point generator
// Raster and circle target generator for a two-axis stage.
// ----------------------------------------------------------------------------
// One request beat gives one result beat. A start beat or a poll that does not
// advance the scan goes straight to the emit state. A raster advance uses the
// restoring divider, which forms the grid step one quotient bit per cycle. A
// circle advance uses one multiply, the same divider for the angle, then one
// CORDIC rotation per cycle. A new request is taken once the current result
// sits in the output register.
module scan_pattern_point_generator #(
  parameter int COORD_SPAN   = scp_pkg::COORD_SPAN_DEF,
  parameter int CORDIC_STEPS = scp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [scp_pkg::IDX_W-1:0]  cfg_wdata_i,
  scp_in_if.sink                     in_if,
  scp_out_if.source                  out_if
);
  import scp_pkg::*;

  localparam int SW    = $clog2(COORD_SPAN + 1);
  localparam int MB_W  = (SW > ANG_W) ? SW : ANG_W;
  localparam int P_W   = IDX_W + MB_W;
  localparam int DVD_W = P_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMUL,
    S_DIVGO,
    S_DIVW,
    S_RMULX,
    S_RMULY,
    S_RSUMY,
    S_CORD,
    S_CNEG,
    S_CFIN,
    S_EMIT
  } state_e;

  state_e state_q;

  logic             pat_q;
  logic [IDX_W-1:0] res_cfg_q;
  logic [IDX_W-1:0] outer_q;
  logic [IDX_W-1:0] inner_q;
  logic             done_q;

  logic [SW-1:0]    step_q;
  logic [P_W-1:0]   prod_q;
  logic signed [XY_W-1:0] x_q;
  logic signed [XY_W-1:0] y_q;
  logic signed [Z_W-1:0]  z_q;
  logic             neg_q;
  logic [STEP_W-1:0] it_q;

  logic               mv_q;
  logic [COORD_W-1:0] tx_q;
  logic [COORD_W-1:0] ty_q;
  logic               fin_q;

  logic               ov_q;
  logic               omv_q;
  logic [COORD_W-1:0] ox_q;
  logic [COORD_W-1:0] oy_q;
  logic               ofin_q;

  logic             in_acc;
  logic             emit_go;
  logic [IDX_W-1:0] res_w;
  logic [IDX_W-1:0] last;

  logic [IDX_W-1:0] mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [P_W-1:0]   prod_d;
  logic [P_W:0]     sum;
  logic [COORD_W-1:0] sat;

  div_status_t      div_st;
  logic [DVD_W-1:0] quo;
  logic             div_go;
  logic [DVD_W-1:0] dvd;

  logic signed [Z_W-1:0] z0;
  logic signed [Z_W-1:0] z1;
  logic signed [Z_W-1:0] z2;
  logic                  fneg;

  logic signed [Z_W-1:0]  at_s;
  logic signed [XY_W-1:0] x_d;
  logic signed [XY_W-1:0] y_d;
  logic signed [Z_W-1:0]  z_d;

  logic signed [XY_W-1:0] xr;
  logic signed [XY_W-1:0] yr;
  logic signed [XY_W-1:0] cx;
  logic signed [XY_W-1:0] cy;

  assign in_acc  = in_if.valid && in_if.ready;
  assign emit_go = (state_q == S_EMIT) && (!ov_q || out_if.ready);
  assign res_w   = (res_cfg_q == '0) ? IDX_W'(1) : res_cfg_q;
  assign last    = res_w - IDX_W'(1);

  always_comb begin
    mul_a = outer_q;
    mul_b = MB_W'(ANG_TURN);
    case (state_q)
      S_RMULX: begin
        mul_a = outer_q;
        mul_b = MB_W'(step_q);
      end
      S_RMULY: begin
        mul_a = inner_q;
        mul_b = MB_W'(step_q);
      end
      default: begin
        mul_a = outer_q;
        mul_b = MB_W'(ANG_TURN);
      end
    endcase
    prod_d = {{MB_W{1'b0}}, mul_a} * {{IDX_W{1'b0}}, mul_b};
    sum    = {1'b0, prod_q} + (P_W + 1)'(step_q >> 1);
    sat    = (sum > (P_W + 1)'(COORD_MAX)) ? COORD_MAX : sum[COORD_W-1:0];
  end

  assign div_go = state_q == S_DIVGO;
  assign dvd    = (pat_q == PAT_CIRCLE) ? prod_q : DVD_W'(COORD_SPAN);

  scp_div #(
    .N (DVD_W),
    .M (IDX_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (dvd),
    .divisor_i  (res_w),
    .status_o   (div_st),
    .quotient_o (quo)
  );

  always_comb begin
    z0   = $signed({{(Z_W - ANG_W){1'b0}}, quo[ANG_W-1:0]});
    z1   = (z0 > ANG_PI_S) ? z0 - ANG_TWO_PI_S : z0;
    z2   = z1;
    fneg = 1'b0;
    if (z1 > ANG_HALF_PI_S) begin
      z2   = z1 - ANG_PI_S;
      fneg = 1'b1;
    end else if (z1 < -ANG_HALF_PI_S) begin
      z2   = z1 + ANG_PI_S;
      fneg = 1'b1;
    end
  end

  always_comb begin
    at_s = $signed({{(Z_W - ATAN_W){1'b0}}, atan_q16(it_q)});
    if (!z_q[Z_W-1]) begin
      x_d = x_q - (y_q >>> it_q);
      y_d = y_q + (x_q >>> it_q);
      z_d = z_q - at_s;
    end else begin
      x_d = x_q + (y_q >>> it_q);
      y_d = y_q - (x_q >>> it_q);
      z_d = z_q + at_s;
    end
  end

  always_comb begin
    xr = x_q + (x_q[XY_W-1] ? TRUNC_RND_S : '0);
    yr = y_q + (y_q[XY_W-1] ? TRUNC_RND_S : '0);
    cx = CENTER_S + (xr >>> FRAC_W);
    cy = CENTER_S + (yr >>> FRAC_W);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q     <= PAT_RASTER;
      res_cfg_q <= RES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PATTERN: pat_q     <= cfg_wdata_i[0];
        CFG_RES:     res_cfg_q <= cfg_wdata_i;
        default:     pat_q     <= pat_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      outer_q <= '0;
      inner_q <= '0;
      done_q  <= 1'b1;
      step_q  <= '0;
      prod_q  <= '0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      neg_q   <= 1'b0;
      it_q    <= '0;
      mv_q    <= 1'b0;
      tx_q    <= '0;
      ty_q    <= '0;
      fin_q   <= 1'b0;
      ov_q    <= 1'b0;
      omv_q   <= 1'b0;
      ox_q    <= '0;
      oy_q    <= '0;
      ofin_q  <= 1'b0;
    end else begin
      if (emit_go) begin
        ov_q <= 1'b1;
      end else if (out_if.valid && out_if.ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            mv_q <= 1'b0;
            tx_q <= '0;
            ty_q <= '0;
            if (in_if.mode == MODE_START) begin
              outer_q <= '0;
              inner_q <= '0;
              done_q  <= 1'b0;
              fin_q   <= 1'b0;
              state_q <= S_EMIT;
            end else if (!done_q && in_if.target_reached) begin
              if (pat_q == PAT_RASTER) begin
                fin_q <= 1'b0;
                if (outer_q >= last && inner_q >= last) begin
                  done_q <= 1'b1;
                  fin_q  <= 1'b1;
                end else if (inner_q < last) begin
                  inner_q <= inner_q + IDX_W'(1);
                end else begin
                  inner_q <= '0;
                  if (outer_q < last) begin
                    outer_q <= outer_q + IDX_W'(1);
                  end
                end
                state_q <= S_DIVGO;
              end else if (outer_q < last) begin
                outer_q <= outer_q + IDX_W'(1);
                fin_q   <= 1'b0;
                state_q <= S_CMUL;
              end else begin
                done_q  <= 1'b1;
                fin_q   <= 1'b1;
                state_q <= S_EMIT;
              end
            end else begin
              fin_q   <= done_q;
              state_q <= S_EMIT;
            end
          end
        end
        S_CMUL: begin
          prod_q  <= prod_d;
          state_q <= S_DIVGO;
        end
        S_DIVGO: begin
          state_q <= S_DIVW;
        end
        S_DIVW: begin
          if (div_st.done) begin
            if (pat_q == PAT_RASTER) begin
              step_q  <= quo[SW-1:0];
              state_q <= S_RMULX;
            end else begin
              z_q     <= z2;
              neg_q   <= fneg;
              x_q     <= RADIUS_GAIN_S;
              y_q     <= '0;
              it_q    <= '0;
              state_q <= S_CORD;
            end
          end
        end
        S_RMULX: begin
          prod_q  <= prod_d;
          state_q <= S_RMULY;
        end
        S_RMULY: begin
          tx_q    <= sat;
          prod_q  <= prod_d;
          mv_q    <= 1'b1;
          state_q <= S_RSUMY;
        end
        S_RSUMY: begin
          ty_q    <= sat;
          state_q <= S_EMIT;
        end
        S_CORD: begin
          x_q  <= x_d;
          y_q  <= y_d;
          z_q  <= z_d;
          it_q <= it_q + STEP_W'(1);
          if (it_q == STEP_W'(CORDIC_STEPS - 1)) begin
            state_q <= S_CNEG;
          end
        end
        S_CNEG: begin
          if (neg_q) begin
            x_q <= -x_q;
            y_q <= -y_q;
          end
          state_q <= S_CFIN;
        end
        S_CFIN: begin
          tx_q    <= cx[COORD_W-1:0];
          ty_q    <= cy[COORD_W-1:0];
          mv_q    <= 1'b1;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            omv_q   <= mv_q;
            ox_q    <= tx_q;
            oy_q    <= ty_q;
            ofin_q  <= fin_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready          = state_q == S_IDLE;
  assign out_if.valid         = ov_q;
  assign out_if.move_valid    = omv_q;
  assign out_if.target_x      = ox_q;
  assign out_if.target_y      = oy_q;
  assign out_if.scan_finished = ofin_q;

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_if.mode == MODE_START |=> outer_q == '0 && inner_q == '0 && !done_q)
    else $error("start beat did not clear scan state");

  a_no_move_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.move_valid |-> out_if.target_x == '0 && out_if.target_y == '0)
    else $error("targets nonzero without move");

  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !div_st.busy)
    else $error("divider busy while idle");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == S_DIVW)
    else $error("divider result outside wait state");

endmodule

### rtl/scp_div.sv
// ----------------------------------------------------------------------------
// Scan pattern restoring divider
// Unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scp_div #(
  parameter int N = 29,
  parameter int M = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [N-1:0]         dividend_i,
  input  logic [M-1:0]         divisor_i,
  output scp_pkg::div_status_t status_o,
  output logic [N-1:0]         quotient_o
);
  import scp_pkg::*;

  localparam int CW = $clog2(N + 1);

  logic [M-1:0]  rem_q;
  logic [N-1:0]  quo_q;
  logic [M-1:0]  dsr_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [M:0]    sh;
  logic          ge;
  logic [M:0]    diff;

  always_comb begin
    sh   = {rem_q, quo_q[N-1]};
    ge   = sh >= {1'b0, dsr_q};
    diff = sh - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q <= '0;
        quo_q <= dividend_i;
        dsr_q <= divisor_i;
        cnt_q <= CW'(N);
      end else if (cnt_q != '0) begin
        rem_q <= ge ? diff[M-1:0] : sh[M-1:0];
        quo_q <= {quo_q[N-2:0], ge};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.busy = cnt_q != '0;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

### test/scan_target_checker.sv
// ----------------------------------------------------------------------------
// Scan target checker
// Watches the request and result channels and the register port of the scan
// pattern point generator. Predicts the stage command for each accepted
// request beat and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module scan_target_checker #(
  parameter int COORD_SPAN   = 700,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [scp_pkg::IDX_W-1:0] cfg_wdata_i,
  scp_in_if                         req_mon,
  scp_out_if                        cmd_mon,
  output int                        mismatch_count_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import scp_pkg::*;

  localparam int     RESET_RES   = 10;
  localparam int     COORD_LIMIT = 1023;
  localparam longint CENTER      = 350;
  localparam longint TURN_Q16    = 411566;
  localparam longint PI_Q16      = 205887;
  localparam longint HALF_PI_Q16 = 102944;
  localparam longint TWO_PI_Q16  = 411775;
  localparam longint GAIN_Q16    = 7959386;
  localparam int     TABLE_LEN   = 24;

  typedef struct packed {
    logic               move_valid;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
    logic               scan_finished;
  } stage_cmd_t;

  logic               pattern;
  logic [IDX_W-1:0]   res_reg;
  int unsigned        outer_idx;
  int unsigned        inner_idx;
  logic               scan_done;
  stage_cmd_t         expected_cmds[$];
  stage_cmd_t         want;
  int                 mismatches;
  int                 pending;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  function automatic longint cordic_angle(input int i);
    case (i)
      0:       return 51472;
      1:       return 30385;
      2:       return 16055;
      3:       return 8150;
      4:       return 4091;
      5:       return 2047;
      6:       return 1024;
      7:       return 512;
      8:       return 256;
      9:       return 128;
      10:      return 64;
      11:      return 32;
      12:      return 16;
      13:      return 8;
      14:      return 4;
      15:      return 2;
      16:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic void circle_xy(input int unsigned k, input int unsigned res,
                                    output logic [COORD_W-1:0] px,
                                    output logic [COORD_W-1:0] py);
    longint ang;
    longint cx;
    longint cy;
    longint nx;
    logic   flip;
    ang  = (longint'(k) * TURN_Q16) / longint'(res);
    cx   = GAIN_Q16;
    cy   = 0;
    flip = 1'b0;
    if (ang > PI_Q16) ang -= TWO_PI_Q16;
    if (ang > HALF_PI_Q16) begin
      ang -= PI_Q16;
      flip = 1'b1;
    end else if (ang < -HALF_PI_Q16) begin
      ang += PI_Q16;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
      if (ang >= 0) begin
        nx  = cx - (cy >>> i);
        cy  = cy + (cx >>> i);
        ang = ang - cordic_angle(i);
      end else begin
        nx  = cx + (cy >>> i);
        cy  = cy - (cx >>> i);
        ang = ang + cordic_angle(i);
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    px = COORD_W'(CENTER + cx / 65536);
    py = COORD_W'(CENTER + cy / 65536);
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input int unsigned v);
    return (v > COORD_LIMIT) ? COORD_W'(COORD_LIMIT) : COORD_W'(v);
  endfunction

  function automatic stage_cmd_t next_command(input logic mode, input logic reached);
    stage_cmd_t  cmd;
    int unsigned res;
    int unsigned last;
    int unsigned pitch;
    cmd  = '0;
    res  = (res_reg == '0) ? 1 : int'(res_reg);
    last = res - 1;
    if (mode == MODE_START) begin
      outer_idx = 0;
      inner_idx = 0;
      scan_done = 1'b0;
    end else if (!scan_done && reached) begin
      if (pattern == PAT_RASTER) begin
        pitch = COORD_SPAN / res;
        if (outer_idx >= last && inner_idx >= last) begin
          scan_done = 1'b1;
        end else if (inner_idx < last) begin
          inner_idx++;
        end else begin
          inner_idx = 0;
          if (outer_idx < last) outer_idx++;
        end
        cmd.move_valid = 1'b1;
        cmd.target_x   = clamp_coord(outer_idx * pitch + pitch / 2);
        cmd.target_y   = clamp_coord(inner_idx * pitch + pitch / 2);
      end else if (outer_idx < last) begin
        outer_idx++;
        circle_xy(outer_idx, res, cmd.target_x, cmd.target_y);
        cmd.move_valid = 1'b1;
      end else begin
        scan_done = 1'b1;
      end
    end
    cmd.scan_finished = scan_done;
    return cmd;
  endfunction

  task automatic compare_field(input string name, input logic [COORD_W-1:0] exp_v,
                               input logic [COORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern    = PAT_RASTER;
      res_reg    = IDX_W'(RESET_RES);
      outer_idx  = 0;
      inner_idx  = 0;
      scan_done  = 1'b1;
      mismatches = 0;
      pending    = 0;
      expected_cmds.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PATTERN) pattern = cfg_wdata_i[0];
        else res_reg = cfg_wdata_i;
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: result beat with no request outstanding", $time);
          mismatches++;
        end else begin
          want = expected_cmds.pop_front();
          compare_field("move_valid", COORD_W'(want.move_valid),
                        COORD_W'(cmd_mon.move_valid));
          compare_field("target_x", want.target_x, cmd_mon.target_x);
          compare_field("target_y", want.target_y, cmd_mon.target_y);
          compare_field("scan_finished", COORD_W'(want.scan_finished),
                        COORD_W'(cmd_mon.scan_finished));
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_cmds.push_back(next_command(req_mon.mode, req_mon.target_reached));
      pending = expected_cmds.size();
    end
  end

endmodule

### test/scan_pattern_point_generator_tb.sv
// ----------------------------------------------------------------------------
// Scan pattern point generator testbench
// Drives request beats and register writes into the generator: a directed
// run over resolution extremes, both patterns and mid-scan resolution
// changes, then random scans under several idle and stall regimes. The
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module scan_pattern_point_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scp_pkg::*;

  localparam int SPAN       = 700;
  localparam int STEPS      = 16;
  localparam int BEAT_GOAL  = 1700;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [0:0]       cfg_idx_i;
  logic [IDX_W-1:0] cfg_wdata_i;

  int send_idle_pct;
  int stall_pct;
  int beats_sent;
  int mismatches;
  int pending;

  scp_in_if  req_ch ();
  scp_out_if cmd_ch ();

  scan_pattern_point_generator #(
    .COORD_SPAN  (SPAN),
    .CORDIC_STEPS(STEPS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (req_ch),
    .out_if     (cmd_ch)
  );

  scan_target_checker #(
    .COORD_SPAN  (SPAN),
    .CORDIC_STEPS(STEPS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_mon         (req_ch),
    .cmd_mon         (cmd_ch),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    cmd_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_beat(input logic mode, input logic reached);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid          <= 1'b1;
    req_ch.mode           <= mode;
    req_ch.target_reached <= reached;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic write_config(input logic pat, input logic [IDX_W-1:0] res);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PATTERN;
    cfg_wdata_i <= IDX_W'(pat);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RES;
    cfg_wdata_i <= res;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_segment(input int count, input bit restart);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (i == 0 && restart) send_beat(MODE_START, 1'($urandom_range(1)));
      else if (pick < 86) send_beat(MODE_UPDATE, 1'b1);
      else if (pick < 93) send_beat(MODE_UPDATE, 1'b0);
      else if (pick < 96) send_beat(MODE_START, 1'($urandom_range(1)));
      else send_beat(1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int   phase;
    int   pick;
    int   res_val;
    int   span;
    logic pat;

    send_idle_pct = 0;
    stall_pct     = 0;
    beats_sent    = 0;
    phase         = 0;
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= CFG_PATTERN;
    cfg_wdata_i           <= '0;
    req_ch.valid          <= 1'b0;
    req_ch.mode           <= MODE_START;
    req_ch.target_reached <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // poll while idle, start with reached set, then default raster
    send_beat(MODE_UPDATE, 1'b1);
    send_beat(MODE_START, 1'b1);
    send_beat(MODE_UPDATE, 1'b0);
    send_beat(MODE_UPDATE, 1'b1);
    send_beat(MODE_UPDATE, 1'b1);
    drain();
    write_config(PAT_RASTER, IDX_W'(1));
    send_beat(MODE_START, 1'b0);
    send_beat(MODE_UPDATE, 1'b1);
    send_beat(MODE_UPDATE, 1'b1);
    drain();
    write_config(PAT_RASTER, IDX_W'(0));
    send_beat(MODE_START, 1'b0);
    send_beat(MODE_UPDATE, 1'b1);
    drain();
    // shrink resolution mid-scan so the last point saturates
    write_config(PAT_RASTER, IDX_W'(3));
    send_beat(MODE_START, 1'b0);
    send_beat(MODE_UPDATE, 1'b1);
    send_beat(MODE_UPDATE, 1'b1);
    send_beat(MODE_UPDATE, 1'b1);
    drain();
    write_config(PAT_RASTER, IDX_W'(1));
    send_beat(MODE_UPDATE, 1'b1);
    drain();
    write_config(PAT_CIRCLE, IDX_W'(1));
    send_beat(MODE_START, 1'b0);
    send_beat(MODE_UPDATE, 1'b1);
    drain();
    write_config(PAT_CIRCLE, IDX_W'(700));
    send_beat(MODE_START, 1'b0);
    send_beat(MODE_UPDATE, 1'b1);
    send_beat(MODE_UPDATE, 1'b1);
    send_beat(MODE_UPDATE, 1'b1);
    drain();
    write_config(PAT_RASTER, IDX_W'(1023));
    send_beat(MODE_START, 1'b0);
    send_beat(MODE_UPDATE, 1'b1);
    send_beat(MODE_UPDATE, 1'b1);
    drain();

    while (beats_sent < BEAT_GOAL) begin
      case ((phase / 4) % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 78;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 78;
        end
        default: begin
          send_idle_pct = 14;
          stall_pct     = 14;
        end
      endcase
      pat  = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 75) begin
        res_val = (pat == PAT_RASTER) ? $urandom_range(6, 1) : $urandom_range(48, 1);
      end else if (pick < 90) begin
        res_val = $urandom_range(1023);
      end else begin
        case ($urandom_range(3))
          0:       res_val = 0;
          1:       res_val = 1;
          2:       res_val = 700;
          default: res_val = 1023;
        endcase
      end
      span = (pat == PAT_RASTER) ? res_val * res_val + 2 : res_val + 2;
      if (span > 60) span = 20 + $urandom_range(40);
      write_config(pat, IDX_W'(res_val));
      run_segment(span, $urandom_range(9) != 0);
      drain();
      phase++;
    end

    repeat (100) @(posedge clk_i);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/scp_pkg.sv
rtl/scp_in_if.sv
rtl/scp_out_if.sv
rtl/scp_div.sv
rtl/scan_pattern_point_generator.sv
test/scan_target_checker.sv
test/scan_pattern_point_generator_tb.sv
